[src/lsp_pkg.sv]
package lsp_pkg;

    localparam int DEF_DEPTH = 128;

    localparam int ACTION_W  = 2;
    localparam int WORD_W    = 32;
    localparam int OUTCOME_W = 2;
    localparam int HELD_W    = 8;

    typedef logic [ACTION_W-1:0]  t_action;
    typedef logic [OUTCOME_W-1:0] t_outcome;

    localparam t_action ACT_PUSH  = 2'd0;
    localparam t_action ACT_POP   = 2'd1;
    localparam t_action ACT_CHECK = 2'd2;

    localparam t_outcome OUT_OK        = 2'd0;
    localparam t_outcome OUT_OVERFLOW  = 2'd1;
    localparam t_outcome OUT_UNDERFLOW = 2'd2;

endpackage

[src/lsp_ram.sv]
module lsp_ram
    import lsp_pkg::*;
#(
    parameter int DEPTH = DEF_DEPTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [AW-1:0]            i_waddr,
    input  logic signed [WORD_W-1:0] i_wdata,
    input  logic [AW-1:0]            i_raddr_a,
    input  logic [AW-1:0]            i_raddr_b,
    output logic signed [WORD_W-1:0] o_rdata_a,
    output logic signed [WORD_W-1:0] o_rdata_b
);

    logic signed [WORD_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

[src/lsp_ctrl.sv]
module lsp_ctrl
    import lsp_pkg::*;
#(
    parameter int DEPTH = DEF_DEPTH,
    parameter int AW    = $clog2(DEPTH),
    parameter int FW    = $clog2(DEPTH + 1)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  t_action                  i_action,
    input  logic signed [WORD_W-1:0] i_value,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [WORD_W-1:0] o_popped_value,
    output t_outcome                 o_outcome,
    output logic                     o_is_palindrome,
    output logic [HELD_W-1:0]        o_entries_held,
    output logic                     o_we,
    output logic [AW-1:0]            o_waddr,
    output logic signed [WORD_W-1:0] o_wdata,
    output logic [AW-1:0]            o_raddr_a,
    output logic [AW-1:0]            o_raddr_b,
    input  logic signed [WORD_W-1:0] i_rdata_a,
    input  logic signed [WORD_W-1:0] i_rdata_b
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_POPW = 4'b0010,
        S_CHKW = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state                   r_state, n_state;
    logic [FW-1:0]            r_fill, n_fill;
    logic [AW-1:0]            r_lo, n_lo, r_hi, n_hi;
    logic signed [WORD_W-1:0] r_res_pop, n_res_pop;
    t_outcome                 r_res_out, n_res_out;
    logic                     r_res_pal, n_res_pal;
    logic                     r_o_valid, n_o_valid;
    logic signed [WORD_W-1:0] r_o_pop, n_o_pop;
    t_outcome                 r_o_out, n_o_out;
    logic                     r_o_pal, n_o_pal;
    logic [HELD_W-1:0]        r_o_held, n_o_held;

    logic                     accept;
    logic                     full;
    logic                     empty;
    logic                     words_equal;
    logic [AW-1:0]            top_addr;
    logic [AW:0]              span;

    assign o_ready     = (r_state == S_IDLE);
    assign accept      = i_valid && o_ready;
    assign full        = (r_fill == FW'(DEPTH));
    assign empty       = (r_fill == '0);
    assign top_addr    = AW'(r_fill - FW'(1));
    assign words_equal = (i_rdata_a == i_rdata_b);
    assign span        = (AW + 1)'(r_hi - r_lo);

    assign o_waddr = AW'(r_fill);
    assign o_wdata = i_value;
    assign o_we    = accept && (i_action == ACT_PUSH) && !full;

    always_comb begin
        if (r_state == S_CHKW) begin
            o_raddr_a = r_lo + AW'(1);
            o_raddr_b = r_hi - AW'(1);
        end else begin
            o_raddr_a = '0;
            o_raddr_b = top_addr;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_res_pop = r_res_pop;
        n_res_out = r_res_out;
        n_res_pal = r_res_pal;
        n_o_valid = r_o_valid && !i_ready;
        n_o_pop   = r_o_pop;
        n_o_out   = r_o_out;
        n_o_pal   = r_o_pal;
        n_o_held  = r_o_held;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_res_pop = '0;
                    n_res_out = OUT_OK;
                    n_res_pal = 1'b0;
                    n_state   = S_OUT;
                    case (i_action)
                        ACT_PUSH: begin
                            if (full) begin
                                n_res_out = OUT_OVERFLOW;
                            end else begin
                                n_fill = r_fill + FW'(1);
                            end
                        end
                        ACT_POP: begin
                            if (empty) begin
                                n_res_out = OUT_UNDERFLOW;
                            end else begin
                                n_fill  = r_fill - FW'(1);
                                n_state = S_POPW;
                            end
                        end
                        ACT_CHECK: begin
                            n_fill = '0;
                            if (r_fill < FW'(2)) begin
                                n_res_pal = 1'b1;
                            end else begin
                                n_lo    = '0;
                                n_hi    = top_addr;
                                n_state = S_CHKW;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_POPW: begin
                n_res_pop = i_rdata_b;
                n_state   = S_OUT;
            end
            S_CHKW: begin
                if (!words_equal) begin
                    n_res_pal = 1'b0;
                    n_state   = S_OUT;
                end else if (span <= (AW + 1)'(2)) begin
                    n_res_pal = 1'b1;
                    n_state   = S_OUT;
                end else begin
                    n_lo = r_lo + AW'(1);
                    n_hi = r_hi - AW'(1);
                end
            end
            S_OUT: begin
                if (!r_o_valid || i_ready) begin
                    n_o_valid = 1'b1;
                    n_o_pop   = r_res_pop;
                    n_o_out   = r_res_out;
                    n_o_pal   = r_res_pal;
                    n_o_held  = HELD_W'(r_fill);
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fill    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_res_pop <= n_res_pop;
        r_res_out <= n_res_out;
        r_res_pal <= n_res_pal;
        r_o_pop   <= n_o_pop;
        r_o_out   <= n_o_out;
        r_o_pal   <= n_o_pal;
        r_o_held  <= n_o_held;
    end

    assign o_valid         = r_o_valid;
    assign o_popped_value  = r_o_pop;
    assign o_outcome       = r_o_out;
    assign o_is_palindrome = r_o_pal;
    assign o_entries_held  = r_o_held;

endmodule

[src/lifo_stack_with_palindrome_check_top.sv]
// Channel   Handshake          Payload
// request   i_valid / o_ready  i_action, i_value
// result    o_valid / i_ready  o_popped_value, o_outcome, o_is_palindrome, o_entries_held
//
// A push goes from S_IDLE straight to S_OUT; a pop passes S_POPW first, set by the registered
// read of the word store. A check compares one entry pair per cycle in S_CHKW through the two
// read ports and the single comparator, until a mismatch or the middle of the stack.
// Reset is synchronous and active low; it empties the stack and needs no clearing pass.
// A finished result waits in the output register while the next request is taken.
module lifo_stack_with_palindrome_check_top
    import lsp_pkg::*;
#(
    parameter int DEPTH = DEF_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  t_action                  i_action,
    input  logic signed [WORD_W-1:0] i_value,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [WORD_W-1:0] o_popped_value,
    output t_outcome                 o_outcome,
    output logic                     o_is_palindrome,
    output logic [HELD_W-1:0]        o_entries_held
);

    localparam int AW = $clog2(DEPTH);

    logic                     we;
    logic [AW-1:0]            waddr;
    logic signed [WORD_W-1:0] wdata;
    logic [AW-1:0]            raddr_a;
    logic [AW-1:0]            raddr_b;
    logic signed [WORD_W-1:0] rdata_a;
    logic signed [WORD_W-1:0] rdata_b;

    lsp_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_action        (i_action),
        .i_value         (i_value),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_popped_value  (o_popped_value),
        .o_outcome       (o_outcome),
        .o_is_palindrome (o_is_palindrome),
        .o_entries_held  (o_entries_held),
        .o_we            (we),
        .o_waddr         (waddr),
        .o_wdata         (wdata),
        .o_raddr_a       (raddr_a),
        .o_raddr_b       (raddr_b),
        .i_rdata_a       (rdata_a),
        .i_rdata_b       (rdata_b)
    );

    lsp_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    a_busy_after_request: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready
    ) else $error("request taken while a request was in progress");

    a_check_empties: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_palindrome) |-> (o_outcome == OUT_OK && o_entries_held == '0)
    ) else $error("palindrome result without an ok outcome and an empty stack");

    a_underflow_zero: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_outcome == OUT_UNDERFLOW) |-> (o_popped_value == '0)
    ) else $error("underflow result carries a non-zero word");

endmodule

[bench/lsp_checker.sv]
`timescale 1ns / 1ps

module lsp_checker
    import lsp_pkg::*;
#(
    parameter int DEPTH = DEF_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_req_valid,
    input  logic                     i_req_ready,
    input  t_action                  i_action,
    input  logic signed [WORD_W-1:0] i_value,
    input  logic                     i_res_valid,
    input  logic                     i_res_ready,
    input  logic signed [WORD_W-1:0] i_popped_value,
    input  t_outcome                 i_outcome,
    input  logic                     i_is_palindrome,
    input  logic [HELD_W-1:0]        i_entries_held,
    output int                       o_errors,
    output int                       o_pending,
    output int                       o_results,
    output int                       o_overflows,
    output int                       o_underflows,
    output int                       o_checks,
    output int                       o_palindromes
);

    typedef struct packed {
        logic signed [WORD_W-1:0] popped_value;
        t_outcome                 outcome;
        logic                     is_palindrome;
        logic [HELD_W-1:0]        entries_held;
    } t_result;

    logic signed [WORD_W-1:0] stack_words [DEPTH];
    int                       stack_fill = 0;
    t_result                  awaited_results [$];

    int error_count     = 0;
    int pending_count   = 0;
    int result_count    = 0;
    int overflow_count  = 0;
    int underflow_count = 0;
    int check_count     = 0;
    int mirror_count    = 0;

    assign o_errors      = error_count;
    assign o_pending     = pending_count;
    assign o_results     = result_count;
    assign o_overflows   = overflow_count;
    assign o_underflows  = underflow_count;
    assign o_checks      = check_count;
    assign o_palindromes = mirror_count;

    function automatic t_result apply_request(input t_action action,
                                              input logic signed [WORD_W-1:0] value);
        t_result outcome_of;
        int      lo;
        int      hi;
        outcome_of = '0;
        outcome_of.outcome = OUT_OK;
        case (action)
            ACT_PUSH: begin
                if (stack_fill >= DEPTH) begin
                    outcome_of.outcome = OUT_OVERFLOW;
                end else begin
                    stack_words[stack_fill] = value;
                    stack_fill++;
                end
            end
            ACT_POP: begin
                if (stack_fill == 0) begin
                    outcome_of.outcome = OUT_UNDERFLOW;
                end else begin
                    stack_fill--;
                    outcome_of.popped_value = stack_words[stack_fill];
                end
            end
            ACT_CHECK: begin
                outcome_of.is_palindrome = 1'b1;
                lo = 0;
                hi = stack_fill - 1;
                while (lo < hi) begin
                    if (stack_words[lo] != stack_words[hi]) begin
                        outcome_of.is_palindrome = 1'b0;
                    end
                    lo++;
                    hi--;
                end
                stack_fill = 0;
            end
            default: begin
            end
        endcase
        outcome_of.entries_held = stack_fill[HELD_W-1:0];
        return outcome_of;
    endfunction

    task automatic compare_field(input string field, input logic signed [63:0] want,
                                 input logic signed [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            stack_fill = 0;
            awaited_results.delete();
        end else begin
            // A result transfer always belongs to an older request, so it is handled first.
            if (i_res_valid && i_res_ready) begin
                result_count++;
                if (awaited_results.size() == 0) begin
                    $display("%0t: result transfer with none awaited, got %0d/%0d/%0d/%0d",
                             $time, i_popped_value, i_outcome, i_is_palindrome,
                             i_entries_held);
                    error_count++;
                end else begin
                    want = awaited_results.pop_front();
                    compare_field("popped_value", want.popped_value, i_popped_value);
                    compare_field("outcome", want.outcome, i_outcome);
                    compare_field("is_palindrome", want.is_palindrome, i_is_palindrome);
                    compare_field("entries_held", want.entries_held, i_entries_held);
                    if (want.outcome == OUT_OVERFLOW) overflow_count++;
                    if (want.outcome == OUT_UNDERFLOW) underflow_count++;
                    if (want.is_palindrome) mirror_count++;
                end
            end
            if (i_req_valid && i_req_ready) begin
                if (i_action == ACT_CHECK) check_count++;
                awaited_results.push_back(apply_request(i_action, i_value));
            end
        end
        pending_count = awaited_results.size();
    end

endmodule

[bench/tb_lifo_stack_with_palindrome_check_top.sv]
`timescale 1ns / 1ps

module tb_lifo_stack_with_palindrome_check_top;
    import lsp_pkg::*;

    localparam int DEPTH        = DEF_DEPTH;
    localparam int ITEM_TARGET  = 650;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = DEPTH / 2 + 20;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_ready;
    t_action                  i_action;
    logic signed [WORD_W-1:0] i_value;
    logic                     o_valid;
    logic                     i_ready;
    logic signed [WORD_W-1:0] o_popped_value;
    t_outcome                 o_outcome;
    logic                     o_is_palindrome;
    logic [HELD_W-1:0]        o_entries_held;

    int errors;
    int pending;
    int results;
    int overflows;
    int underflows;
    int checks;
    int palindromes;

    int tx_idle_pct  = 11;
    int rx_stall_pct = 88;
    int items_sent   = 0;
    int stim_fill    = 0;
    int full_runs    = 0;
    int cycle_count  = 0;

    lifo_stack_with_palindrome_check_top #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_action       (i_action),
        .i_value        (i_value),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_popped_value (o_popped_value),
        .o_outcome      (o_outcome),
        .o_is_palindrome(o_is_palindrome),
        .o_entries_held (o_entries_held)
    );

    lsp_checker #(
        .DEPTH(DEPTH)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_valid    (i_valid),
        .i_req_ready    (o_ready),
        .i_action       (i_action),
        .i_value        (i_value),
        .i_res_valid    (o_valid),
        .i_res_ready    (i_ready),
        .i_popped_value (o_popped_value),
        .i_outcome      (o_outcome),
        .i_is_palindrome(o_is_palindrome),
        .i_entries_held (o_entries_held),
        .o_errors       (errors),
        .o_pending      (pending),
        .o_results      (results),
        .o_overflows    (overflows),
        .o_underflows   (underflows),
        .o_checks       (checks),
        .o_palindromes  (palindromes)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_lifo_stack_with_palindrome_check_top: done, errors");
            $finish;
        end
    end

    function automatic logic signed [WORD_W-1:0] rand_word();
        case ($urandom_range(0, 7))
            0: return {1'b1, {(WORD_W-1){1'b0}}};
            1: return {1'b0, {(WORD_W-1){1'b1}}};
            2: return '0;
            3: return '1;
            4: return $urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    task automatic send(input t_action action, input logic signed [WORD_W-1:0] value);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid  <= 1'b1;
        i_action <= action;
        i_value  <= value;
        do @(posedge i_clk); while (!o_ready);
        items_sent++;
        case (action)
            ACT_PUSH:  if (stim_fill < DEPTH) stim_fill++;
            ACT_POP:   if (stim_fill > 0) stim_fill--;
            ACT_CHECK: stim_fill = 0;
            default: begin
            end
        endcase
    endtask

    task automatic wait_for_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // Pushes a word sequence that reads the same both ways, or one with a single bit spoilt.
    task automatic push_mirror(input int count, input bit spoil);
        logic signed [WORD_W-1:0] words [];
        int                       spot;
        words = new[count];
        for (int i = 0; i < (count + 1) / 2; i++) begin
            words[i] = rand_word();
            words[count-1-i] = words[i];
        end
        if (spoil && count >= 2) begin
            spot = $urandom_range(0, count / 2 - 1);
            words[spot] = words[spot] ^ ({{(WORD_W-1){1'b0}}, 1'b1} << $urandom_range(0, 31));
        end
        foreach (words[i]) send(ACT_PUSH, words[i]);
    endtask

    initial begin
        int phase;
        int pick;
        i_rst_n  = 1'b0;
        i_valid  = 1'b0;
        i_action = ACT_PUSH;
        i_value  = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send(ACT_CHECK, '0);
        send(ACT_POP, '1);
        send(t_action'(3), '1);
        send(ACT_PUSH, {1'b1, {(WORD_W-1){1'b0}}});
        send(ACT_PUSH, {1'b0, {(WORD_W-1){1'b1}}});
        send(ACT_PUSH, '0);
        send(ACT_PUSH, '1);
        send(t_action'(3), 32'sd77);
        send(ACT_POP, '0);
        send(ACT_POP, '0);
        send(ACT_CHECK, '0);
        send(ACT_PUSH, 32'sd5);
        send(ACT_PUSH, -32'sd7);
        send(ACT_PUSH, 32'sd5);
        send(ACT_CHECK, '0);
        send(ACT_PUSH, {1'b0, {(WORD_W-1){1'b1}}});
        send(ACT_CHECK, '0);
        send(ACT_PUSH, 32'sd3);
        send(ACT_PUSH, 32'sd3);
        send(ACT_CHECK, '0);
        send(ACT_PUSH, 32'sd1);
        send(ACT_PUSH, 32'sd2);
        send(ACT_CHECK, '0);

        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            if (items_sent * 3 / ITEM_TARGET > phase) begin
                phase = items_sent * 3 / ITEM_TARGET;
                wait_for_results();
                tx_idle_pct  = (phase == 1) ? 88 : 0;
                rx_stall_pct = (phase == 1) ? 11 : 0;
            end
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                if (stim_fill != 0 && $urandom_range(0, 3) != 0) send(ACT_CHECK, $urandom);
                push_mirror($urandom_range(0, 9), $urandom_range(0, 1));
                send(ACT_CHECK, $urandom);
            end else if (pick < 46 && full_runs < 2) begin
                if (stim_fill != 0) send(ACT_CHECK, $urandom);
                push_mirror(DEPTH, $urandom_range(0, 1));
                repeat ($urandom_range(1, 3)) send(ACT_PUSH, $urandom);
                if ($urandom_range(0, 1)) repeat ($urandom_range(1, 4)) send(ACT_POP, $urandom);
                send(ACT_CHECK, $urandom);
                full_runs++;
            end else if (pick < 70) begin
                repeat ($urandom_range(8, 20))
                    send(($urandom_range(0, 9) < 6) ? ACT_PUSH : ACT_POP, rand_word());
            end else if (pick < 82) begin
                repeat (stim_fill + $urandom_range(1, 3)) send(ACT_POP, $urandom);
            end else begin
                repeat ($urandom_range(1, 4)) send(t_action'($urandom_range(0, 3)), $urandom);
            end
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Sent %0d requests and compared %0d results, %0d of them full-depth runs.",
                 items_sent, results, full_runs);
        $display("Saw %0d overflows, %0d underflows and %0d checks, %0d of them palindromes.",
                 overflows, underflows, checks, palindromes);
        if (errors == 0 && pending == 0) begin
            $display("tb_lifo_stack_with_palindrome_check_top: done, clean");
        end else begin
            $display("tb_lifo_stack_with_palindrome_check_top: done, errors");
        end
        $finish;
    end

endmodule

[sim.f]
src/lsp_pkg.sv
src/lsp_ram.sv
src/lsp_ctrl.sv
src/lifo_stack_with_palindrome_check_top.sv
bench/lsp_checker.sv
bench/tb_lifo_stack_with_palindrome_check_top.sv
